/* rtl/diff_drive_odometry_integrator_core_assert.svh */
// Assertion macros shared by the odometry integrator RTL.
// ASSERT_CLK is checked at every rising clk edge outside reset.
// ASSERT_ALWAYS is checked at every rising clk edge, reset included.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/ddoi_pkg.sv */
package ddoi_pkg;

  // Iteration count of the rotator and its upper bound.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 32;

  // Datapath widths.
  localparam int CW   = 34;  // rotator x, y, z and sin/cos results, Q2.30
  localparam int MA_W = 26;  // multiplier operand a
  localparam int MB_W = 34;  // multiplier operand b
  localparam int MP_W = 60;  // product

  localparam logic [15:0]          DT_RESET    = 16'd1311;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  // 2^26 / (4*pi): radians in Q26 to the binary heading angle.
  localparam logic signed [MB_W-1:0] RAD_TO_BAM = 34'sd5340354;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] linear_speed;
    logic signed [23:0] turn_rate;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [23:0] echo_linear;
    logic signed [23:0] echo_turn;
  } res_t;

  typedef struct packed {
    logic [15:0] time_step;
  } cfg_t;

  // Rotator status and results as seen by the sequencer.
  typedef struct packed {
    logic                done;
    logic signed [CW-1:0] cos_val;
    logic signed [CW-1:0] sin_val;
  } cord_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT1,
    ST_MXC,
    ST_MXD,
    ST_MYS,
    ST_MYD,
    ST_MTD,
    ST_MKL,
    ST_MKH,
    ST_HUPD,
    ST_ROT2,
    ST_DONE
  } state_t;

  // Arctangent of 2^-i as a binary angle, 2^32 = 2*pi.
  function automatic logic signed [CW-1:0] atan_of(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {2'b00, v};
  endfunction

endpackage

/* rtl/ddoi_chan_if.sv */
// Valid/ready channel carrying one request of the given payload type.
interface ddoi_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/ddoi_cordic.sv */
`include "diff_drive_odometry_integrator_core_assert.svh"

// Rotation-mode CORDIC, one micro-rotation per cycle.
module ddoi_cordic #(
  parameter int STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           angle,
  output ddoi_pkg::cord_res_t   res
);
  import ddoi_pkg::*;

  localparam int NITER = (STEPS < CORDIC_MAX) ? STEPS : CORDIC_MAX;
  localparam int IW    = $clog2(NITER);
  localparam logic [IW-1:0] LAST = IW'(NITER - 1);

  logic                 busy;
  logic [IW-1:0]        iter;
  logic [1:0]           quad;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;
  logic signed [CW-1:0] zr;

  logic [1:0]           quad_in;
  logic [31:0]          red;
  logic signed [CW-1:0] z_init;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic signed [CW-1:0] z_next;
  logic                 last;

  // Fold the angle into the quarter turn around zero.
  always_comb begin
    quad_in = angle[31:30] + {1'b0, angle[29]};
    red     = angle - {quad_in, 30'b0};
    z_init  = {{(CW - 32){red[31]}}, red};
  end

  // One micro-rotation toward z = 0.
  always_comb begin
    sx = xr >>> iter;
    sy = yr >>> iter;
    if (!zr[CW-1]) begin
      x_next = xr - sy;
      y_next = yr + sx;
      z_next = zr - atan_of(5'(iter));
    end else begin
      x_next = xr + sy;
      y_next = yr - sx;
      z_next = zr + atan_of(5'(iter));
    end
  end

  assign last = busy && (iter == LAST);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == LAST) begin
        busy <= 1'b0;
        iter <= '0;
      end else begin
        iter <= iter + 1'b1;
      end
    end
  end

  // Rotation vector and residual angle.
  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= CORDIC_GAIN;
      yr   <= '0;
      zr   <= z_init;
      quad <= quad_in;
    end else if (busy) begin
      xr <= x_next;
      yr <= y_next;
      zr <= z_next;
    end
  end

  // Put the quarter turn back.
  always_comb begin
    res.done = last;
    case (quad)
      2'd0: begin
        res.cos_val = xr;
        res.sin_val = yr;
      end
      2'd1: begin
        res.cos_val = -yr;
        res.sin_val = xr;
      end
      2'd2: begin
        res.cos_val = -xr;
        res.sin_val = -yr;
      end
      default: begin
        res.cos_val = yr;
        res.sin_val = -xr;
      end
    endcase
  end

  `ASSERT_CLK(a_start_idle, start |-> !busy, "rotator started while busy")
  `ASSERT_CLK(a_runs_on, busy && !last && !start |=> busy, "rotator stopped early")
  `ASSERT_CLK(a_hold, !busy && !start |=> $stable(xr) && $stable(yr), "result not held")

endmodule

/* rtl/ddoi_mul.sv */
// Shared signed multiplier with a registered product.
module ddoi_mul (
  input  logic                               clk,
  input  logic signed [ddoi_pkg::MA_W-1:0]   a,
  input  logic signed [ddoi_pkg::MB_W-1:0]   b,
  output logic signed [ddoi_pkg::MP_W-1:0]   prod
);
  import ddoi_pkg::*;

  logic signed [MP_W-1:0] full;

  assign full = MP_W'(a) * MP_W'(b);

  always_ff @(posedge clk) begin
    prod <= full;
  end

endmodule

/* rtl/diff_drive_odometry_integrator_core.sv */
// Channel  Dir  Payload                                         Accepted when
// req      in   kind, linear_speed, turn_rate                   req.valid & req.ready
// res      out  pos_x, pos_y, heading_angle, quat_z, quat_w,    res.valid & res.ready
//               echo_linear, echo_turn
// cfg      in   time_step                                       cfg.valid & cfg.ready
//
// A command request is taken while the block is idle and gives no result.
// A tick request keeps the block busy through two passes of the one-rotation-per-cycle
// CORDIC and seven passes through the single shared multiplier; a pending result stalls
// the block only at its final step.
// Reset sets the pose, heading and stored speeds to zero and time_step to 1311.
`include "diff_drive_odometry_integrator_core_assert.svh"

module diff_drive_odometry_integrator_core #(
  parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input logic         clk,
  input logic         rst,
  ddoi_chan_if.sink   req,
  ddoi_chan_if.source res,
  ddoi_chan_if.sink   cfg
);
  import ddoi_pkg::*;

  state_t state;
  state_t state_next;

  logic [15:0]          dt;
  logic signed [31:0]   pose_x;
  logic signed [31:0]   pose_y;
  logic [31:0]          heading;
  logic signed [23:0]   cmd_linear;
  logic signed [23:0]   cmd_turn;
  logic signed [23:0]   phi;
  logic [40:0]          acc;
  logic                 res_valid;
  res_t                 res_data;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic                   cord_start;
  logic [31:0]            cord_angle;
  cord_res_t              cord;

  logic                   tick_req;
  logic                   load_out;
  logic signed [MP_W-1:0] t30;
  logic signed [MA_W-1:0] p16;
  logic signed [MP_W-1:0] t16;
  logic signed [25:0]     dpos;
  logic signed [31:0]     cur_pose;
  logic signed [33:0]     pos_sum;
  logic signed [31:0]     pos_sat;
  logic [63:0]            hsum;
  logic [31:0]            heading_next;

  // Round Q2.30 to Q1.15 and clamp to the 16-bit range.
  function automatic logic signed [15:0] q15_of(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [19:0] r;
    t = (CW + 1)'(v) + (CW + 1)'(1 << 14);
    r = t[34:15];
    if (r > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -20'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  ddoi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (cord_angle),
    .res   (cord)
  );

  ddoi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign tick_req = req.valid && (req.payload.kind == KIND_TICK);

  // Rounding of the products and the saturating pose update.
  always_comb begin
    t30      = prod + MP_W'(1 << 29);
    p16      = t30[55:30];
    t16      = prod + MP_W'(1 << 15);
    dpos     = t16[41:16];
    cur_pose = (state == ST_MYS) ? pose_x : pose_y;
    pos_sum  = 34'(cur_pose) + 34'(dpos);
    if (pos_sum[33:31] == 3'b000 || pos_sum[33:31] == 3'b111) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[33]) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'sh7FFF_FFFF;
    end
  end

  // Heading step: high partial product shifted up plus low partial product, rounded.
  always_comb begin
    hsum         = {prod[46:0], 17'b0} + {23'b0, acc} + 64'h0000_0000_0200_0000;
    heading_next = heading + hsum[57:26];
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick_req) begin
          state_next = ST_ROT1;
        end
      end
      ST_ROT1: begin
        if (cord.done) begin
          state_next = ST_MXC;
        end
      end
      ST_MXC:  state_next = ST_MXD;
      ST_MXD:  state_next = ST_MYS;
      ST_MYS:  state_next = ST_MYD;
      ST_MYD:  state_next = ST_MTD;
      ST_MTD:  state_next = ST_MKL;
      ST_MKL:  state_next = ST_MKH;
      ST_MKH:  state_next = ST_HUPD;
      ST_HUPD: state_next = ST_ROT2;
      ST_ROT2: begin
        if (cord.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, rotator start and multiplier operands.
  always_comb begin
    req.ready  = (state == ST_IDLE);
    cord_start = ((state == ST_IDLE) && tick_req) || (state == ST_HUPD);
    cord_angle = (state == ST_HUPD) ? heading_next : {heading[30:0], 1'b0};
    load_out   = (state == ST_DONE) && (!res_valid || res.ready);
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_MXC: begin
        mul_a = MA_W'(cmd_linear);
        mul_b = cord.cos_val;
      end
      ST_MXD: begin
        mul_a = p16;
        mul_b = {{(MB_W - 16){1'b0}}, dt};
      end
      ST_MYS: begin
        mul_a = MA_W'(cmd_linear);
        mul_b = cord.sin_val;
      end
      ST_MYD: begin
        mul_a = p16;
        mul_b = {{(MB_W - 16){1'b0}}, dt};
      end
      ST_MTD: begin
        mul_a = MA_W'(cmd_turn);
        mul_b = {{(MB_W - 16){1'b0}}, dt};
      end
      ST_MKL: begin
        mul_a = {{(MA_W - 17){1'b0}}, prod[16:0]};
        mul_b = RAD_TO_BAM;
      end
      ST_MKH: begin
        mul_a = MA_W'(phi);
        mul_b = RAD_TO_BAM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cfg.ready   = 1'b1;
  assign res.valid   = res_valid;
  assign res.payload = res_data;

  // Control state and the odometry state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      res_valid  <= 1'b0;
      dt         <= DT_RESET;
      pose_x     <= '0;
      pose_y     <= '0;
      heading    <= '0;
      cmd_linear <= '0;
      cmd_turn   <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        dt <= cfg.payload.time_step;
      end
      if (req.valid && req.ready && (req.payload.kind == KIND_CMD)) begin
        cmd_linear <= req.payload.linear_speed;
        cmd_turn   <= req.payload.turn_rate;
      end
      if (state == ST_MYS) begin
        pose_x <= pos_sat;
      end
      if (state == ST_MTD) begin
        pose_y <= pos_sat;
      end
      if (state == ST_HUPD) begin
        heading <= heading_next;
      end
    end
  end

  // Partial products of the heading step.
  always_ff @(posedge clk) begin
    if (state == ST_MKL) begin
      phi <= prod[40:17];
    end
    if (state == ST_MKH) begin
      acc <= prod[40:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      res_data.pos_x         <= pose_x;
      res_data.pos_y         <= pose_y;
      res_data.heading_angle <= heading;
      res_data.quat_z        <= q15_of(cord.sin_val);
      res_data.quat_w        <= q15_of(cord.cos_val);
      res_data.echo_linear   <= cmd_linear;
      res_data.echo_turn     <= cmd_turn;
    end
  end

  `ASSERT_CLK(a_heading_hold, state != ST_HUPD |=> $stable(heading), "heading moved")
  `ASSERT_CLK(a_pose_hold, !(state == ST_MYS || state == ST_MTD) |=> $stable(pose_x) && $stable(pose_y), "pose moved")
  `ASSERT_CLK(a_result_src, $rose(res_valid) |-> $past(state == ST_DONE), "result without a tick")

endmodule

/* verif/ddoi_pose_checker.sv */
// Watches the request, result and time-step channels of the odometry integrator,
// keeps its own copy of the pose and the stored speeds, and compares every result
// with the pose it predicts for the oldest tick that is still waiting.
module ddoi_pose_checker #(
  parameter int ROT_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  ddoi_pkg::req_t req_payload,
  input  logic           res_valid,
  input  logic           res_ready,
  input  ddoi_pkg::res_t res_payload,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  ddoi_pkg::cfg_t cfg_payload,
  output int             fail_count,
  output int             pending,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ddoi_pkg::*;

  // Rotator gain in Q2.30 and the radians-to-heading scale in Q26.
  localparam longint ROT_GAIN       = 64'sd652032874;
  localparam longint RAD_TO_HEADING = 64'sd5340354;
  localparam logic [15:0] STEP_AT_RESET = 16'd1311;

  // Arctangent of 2^-i as a binary angle with 2^32 equal to a full turn.
  longint atan_lut [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };

  // Predicted state of the block.
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [31:0]        hdg;
  logic signed [23:0] spd;
  logic signed [23:0] rate;
  logic [15:0]        step_dt;

  // Poses predicted for ticks whose results have not come out yet.
  res_t pose_q [$];

  // Add half an LSB of the target scale, then drop n bits with floor.
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input longint v);
    longint r;
    r = round_shift(v, 15);
    if (r > 64'sd32767) return 16'sh7FFF;
    if (r < -64'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // Cosine and sine in Q2.30 of a binary angle with 2^32 equal to 2*pi.
  // The angle is first folded into +-pi/4 by whole quarter turns.
  function automatic void rotate_bam(input logic [31:0] ang, output longint cs,
                                     output longint sn);
    logic [31:0] shifted;
    logic [31:0] ru;
    logic [1:0]  quad;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    int          i;
    shifted = ang + 32'h2000_0000;
    quad = shifted[31:30];
    ru = ang - {quad, 30'd0};
    z = longint'($signed(ru));
    x = ROT_GAIN;
    y = 0;
    for (i = 0; i < ROT_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end
      x = nx;
    end
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // Distance covered along one axis in one step, Q16.16.
  function automatic longint travel(input logic signed [23:0] v, input longint trig);
    return round_shift(round_shift(longint'(v) * trig, 30) * longint'(step_dt), 16);
  endfunction

  // One tick: move along the old heading, turn, then report the new pose.
  function automatic res_t advance_pose();
    longint cs;
    longint sn;
    longint dh;
    res_t   r;
    rotate_bam({hdg[30:0], 1'b0}, cs, sn);
    px = clamp32(longint'(px) + travel(spd, cs));
    py = clamp32(longint'(py) + travel(spd, sn));
    dh = round_shift(longint'(rate) * longint'(step_dt) * RAD_TO_HEADING, 26);
    hdg = hdg + dh[31:0];
    rotate_bam(hdg, cs, sn);
    r.pos_x = px;
    r.pos_y = py;
    r.heading_angle = hdg;
    r.quat_z = to_q15(sn);
    r.quat_w = to_q15(cs);
    r.echo_linear = spd;
    r.echo_turn = rate;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Results are checked before the request of the same edge is predicted,
  // since a tick taken now cannot have its result out at the same edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      px = '0;
      py = '0;
      hdg = '0;
      spd = '0;
      rate = '0;
      step_dt = STEP_AT_RESET;
      pose_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_dt = cfg_payload.time_step;
      end
      if (res_valid && res_ready) begin
        if (pose_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no tick waiting, expected none, actual %0h",
                   $time, res_payload);
        end else begin
          want = pose_q.pop_front();
          compare_field("pos_x", want.pos_x, res_payload.pos_x);
          compare_field("pos_y", want.pos_y, res_payload.pos_y);
          compare_field("heading_angle", want.heading_angle, res_payload.heading_angle);
          compare_field("quat_z", want.quat_z, res_payload.quat_z);
          compare_field("quat_w", want.quat_w, res_payload.quat_w);
          compare_field("echo_linear", want.echo_linear, res_payload.echo_linear);
          compare_field("echo_turn", want.echo_turn, res_payload.echo_turn);
          checked++;
        end
      end
      if (req_valid && req_ready) begin
        if (req_payload.kind == KIND_TICK) begin
          pose_q.push_back(advance_pose());
        end else begin
          spd = req_payload.linear_speed;
          rate = req_payload.turn_rate;
        end
      end
    end
    pending = pose_q.size();
  end

endmodule

/* verif/diff_drive_odometry_integrator_core_tb.sv */
// Stimulus and verdict for the odometry integrator. Requests and the result
// side run with random gaps; the pose checker beside the block does the compare.
module diff_drive_odometry_integrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddoi_pkg::*;

  // Wait after a drain, longer than a tick takes; this leaves room for a command still in flight.
  localparam int SETTLE      = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPEED_MIN = 24'sh800000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  int   sent;
  int   steps_used;
  int   cycles;
  bit   no_idle;

  ddoi_chan_if #(.payload_t(req_t)) req_ch ();
  ddoi_chan_if #(.payload_t(res_t)) res_ch ();
  ddoi_chan_if #(.payload_t(cfg_t)) cfg_ch ();

  diff_drive_odometry_integrator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  ddoi_pose_checker pose_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_payload (req_ch.payload),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_payload (res_ch.payload),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_payload (cfg_ch.payload),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("diff_drive_odometry_integrator_core test failed");
    $finish;
  end

  // Result side: random hold-offs per result, and twice a long stall so the
  // block backs up and stops taking requests.
  initial begin
    int gap;
    int taken;
    res_ch.ready = 1'b0;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (taken == 40 || taken == 250) gap = 300;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  function automatic logic [23:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  // Speeds lean on the extremes; a wide pick is full scale seven times in ten.
  function automatic logic signed [23:0] pick_speed(input bit wide);
    logic [23:0] r;
    int          sel;
    r = rand24();
    sel = $urandom_range(0, 9);
    if (wide && sel < 7) return sel[0] ? SPEED_MAX : SPEED_MIN;
    case (sel)
      0: return '0;
      1: return SPEED_MAX;
      2: return SPEED_MIN;
      3: return {{14{r[9]}}, r[9:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic signed [23:0] pick_turn(input bit wide);
    if (wide && $urandom_range(0, 4) < 3) return '0;
    return pick_speed(wide);
  endfunction

  // Offer one request after a random gap and return at the falling edge after
  // it was taken, with valid still high so a back-to-back request needs no toggle.
  task automatic send_req(input kind_t k, input logic signed [23:0] lin,
                          input logic signed [23:0] turn);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.payload <= '{kind: k, linear_speed: lin, turn_rate: turn};
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // Ticks carry junk in the speed fields, which the block must ignore.
  task automatic send_tick();
    send_req(KIND_TICK, rand24(), rand24());
  endtask

  // Change the time step only once the block has drained.
  task automatic write_step(input logic [15:0] value);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_ch.payload <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    steps_used++;
  endtask

  // Mostly a command followed by a run of ticks; the rest are lone requests.
  task automatic run_stream(input int count, input bit wide);
    int done_items;
    int run;
    done_items = 0;
    while (done_items < count) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) begin
        send_req(kind_t'($urandom_range(0, 1)), pick_speed(wide), pick_turn(wide));
        done_items++;
      end else begin
        run = wide ? $urandom_range(10, 40) : $urandom_range(1, 8);
        send_req(KIND_CMD, pick_speed(wide), pick_turn(wide));
        repeat (run) send_tick();
        done_items += run + 1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    bit dir;
    logic signed [23:0] cruise;
    logic signed [23:0] retreat;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    no_idle = 1'b0;
    sent = 0;
    steps_used = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: standing start, both speed extremes, unit speeds and a
    // command overwritten before any tick uses it.
    send_tick();
    send_req(KIND_CMD, SPEED_MAX, SPEED_MAX);
    send_tick();
    send_tick();
    send_req(KIND_CMD, SPEED_MIN, SPEED_MIN);
    send_req(KIND_TICK, SPEED_MAX, SPEED_MIN);
    send_tick();
    send_req(KIND_CMD, 24'sd65536, 24'sd0);
    send_tick();
    send_req(KIND_CMD, 24'sd0, 24'sd102944);
    send_tick();
    send_tick();
    send_req(KIND_CMD, 24'sd1, -24'sd1);
    send_tick();
    send_req(KIND_CMD, -24'sd1, 24'sd1);
    send_tick();
    send_req(KIND_CMD, '0, '0);
    send_req(KIND_CMD, SPEED_MAX, SPEED_MIN);
    send_req(KIND_TICK, SPEED_MIN, SPEED_MAX);
    send_tick();

    // Random traffic at the reset time step.
    run_stream(150, 1'b0);

    // Longest step: drive straight at full speed until one axis pins at its
    // limit, then back off out of saturation.
    write_step(16'hFFFF);
    dir = $urandom_range(0, 1);
    cruise = dir ? SPEED_MAX : SPEED_MIN;
    retreat = dir ? SPEED_MIN : SPEED_MAX;
    send_req(KIND_CMD, cruise, '0);
    repeat ($urandom_range(380, 400)) send_tick();
    send_req(KIND_CMD, retreat, '0);
    repeat (40) send_tick();
    run_stream(80, 1'b1);

    // Shortest nonzero step, then a zero step that must not move anything.
    write_step(16'd1);
    run_stream(80, 1'b0);
    write_step(16'd0);
    run_stream(40, 1'b0);

    // Random steps, then back to the default.
    write_step(16'($urandom_range(1, 65535)));
    run_stream(75, 1'b0);
    write_step(16'($urandom_range(1, 65535)));
    run_stream(75, 1'b1);
    write_step(16'd1311);
    run_stream(40, 1'b0);

    // Drain and let the block settle before the verdict.
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Sent %0d requests and checked %0d pose results over %0d time-step writes,",
             sent, checked, steps_used);
    $display("covering speed extremes, saturated pose, heading wrap, zero step and stalls.");
    if (fail_count == 0) begin
      $display("diff_drive_odometry_integrator_core test passed");
    end else begin
      $display("diff_drive_odometry_integrator_core test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ddoi_pkg.sv
rtl/ddoi_chan_if.sv
rtl/ddoi_cordic.sv
rtl/ddoi_mul.sv
rtl/diff_drive_odometry_integrator_core.sv
verif/ddoi_pose_checker.sv
verif/diff_drive_odometry_integrator_core_tb.sv
